@@ rtl/prsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prsp_pkg
// Types, constants and helper functions for the pixel run segmenter with
// segment-type pattern detection.
// ----------------------------------------------------------------------------
package prsp_pkg;

	// row geometry and pattern size
	localparam int ROW_MAX     = 1024;
	localparam int PATTERN_LEN = 5;
	localparam int HIST_DEPTH  = PATTERN_LEN - 1;
	localparam int INDEX_MAX   = 1023;

	// field widths
	localparam int PIX_W   = 8;
	localparam int TYPE_W  = 2;
	localparam int LEN_W   = 11;
	localparam int IDX_W   = 10;
	localparam int CFG_W   = 10;
	localparam int OUT_TDATA_W = 40;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// reset value of the pattern register (1,3,2,3,1)
	localparam logic [CFG_W-1:0] PATTERN_RESET = 10'd493;

	// pixel values that form segments and their type codes
	localparam logic [PIX_W-1:0]  PIX_BLACK = 8'd0;
	localparam logic [PIX_W-1:0]  PIX_GRAY  = 8'd128;
	localparam logic [PIX_W-1:0]  PIX_WHITE = 8'd255;
	localparam logic [TYPE_W-1:0] SEG_NONE  = 2'd0;
	localparam logic [TYPE_W-1:0] SEG_BLACK = 2'd1;
	localparam logic [TYPE_W-1:0] SEG_GRAY  = 2'd2;
	localparam logic [TYPE_W-1:0] SEG_WHITE = 2'd3;

	typedef logic [HIST_DEPTH-1:0][TYPE_W-1:0] hist_t;

	// per-row match bookkeeping
	typedef struct packed {
		hist_t              hist;
		logic [IDX_W-1:0]   seg_idx;
		logic               found;
	} row_t;

	// one result item
	typedef struct packed {
		logic [TYPE_W-1:0] seg_type;
		logic [LEN_W-1:0]  seg_length;
		logic [LEN_W-1:0]  seg_midpoint;
		logic              pattern_hit;
		logic [IDX_W-1:0]  pattern_start;
		logic              last_of_row;
	} res_t;

	typedef struct packed {
		res_t res;
		row_t row;
	} emit_t;

	function automatic logic [TYPE_W-1:0] classify(logic [PIX_W-1:0] p);
		logic [TYPE_W-1:0] c;
		c = SEG_NONE;
		if (p == PIX_BLACK) c = SEG_BLACK;
		else if (p == PIX_GRAY) c = SEG_GRAY;
		else if (p == PIX_WHITE) c = SEG_WHITE;
		return c;
	endfunction

	// entries past the register width read as type none
	function automatic logic [TYPE_W-1:0] pattern_at(logic [CFG_W-1:0] pat, int i);
		return TYPE_W'(pat >> (TYPE_W * i));
	endfunction

	// close one segment: result fields plus the updated row bookkeeping
	function automatic emit_t emit_seg(row_t st, logic [TYPE_W-1:0] typ,
			logic [LEN_W-1:0] len, logic [LEN_W-1:0] start, logic [CFG_W-1:0] pat);
		logic [LEN_W:0] mid;
		logic           ok;
		emit_t          e;
		mid = {1'b0, start} + {2'b0, len[LEN_W-1:1]};
		if (mid > (LEN_W+1)'(ROW_MAX)) mid = (LEN_W+1)'(ROW_MAX);

		ok = !st.found && (st.seg_idx >= IDX_W'(PATTERN_LEN - 1))
			&& (typ == pattern_at(pat, PATTERN_LEN - 1));
		for (int i = 0; i < HIST_DEPTH; i++) begin
			if (st.hist[i] != pattern_at(pat, i)) ok = 1'b0;
		end

		e.res.seg_type      = typ;
		e.res.seg_length    = len;
		e.res.seg_midpoint  = mid[LEN_W-1:0];
		e.res.pattern_hit   = ok;
		e.res.pattern_start = ok ? st.seg_idx - IDX_W'(PATTERN_LEN - 1) : '0;
		e.res.last_of_row   = 1'b0;

		// oldest type at index 0
		for (int i = 0; i < HIST_DEPTH - 1; i++) begin
			e.row.hist[i] = st.hist[i+1];
		end
		e.row.hist[HIST_DEPTH-1] = typ;
		e.row.seg_idx = (st.seg_idx < IDX_W'(INDEX_MAX)) ? st.seg_idx + 1'b1 : st.seg_idx;
		e.row.found   = st.found | ok;
		return e;
	endfunction

endpackage
`default_nettype wire

@@ rtl/pixel_run_segmenter_pattern_detect_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_run_segmenter_pattern_detect_unit
// Splits a pixel row into runs of black, gray and white pixels and flags the
// first run sequence that matches a programmable type pattern.
// ----------------------------------------------------------------------------
// The unit takes one pixel item per clock while the result queue has room:
// run tracking and the pattern compare over the last five segment types
// finish in the cycle the item is accepted, and the result items it causes,
// at most two, go into a four-entry result queue that drives the output port
// one item per clock while the output side is ready. An input item is accepted
// whenever at least two queue entries are free, so with the output side ready
// the input side never stalls; an item that closes one run, opens another and
// also ends the row yields two result items. The pattern register may be
// written at any idle time; the write channel is always ready.
module pixel_run_segmenter_pattern_detect_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// pattern register write
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [prsp_pkg::CFG_W-1:0]          cfg_data,
	// pixel items
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [prsp_pkg::PIX_W-1:0]          s_axis_tdata,  // pixel[7:0]
	input  wire logic                                s_axis_tlast,  // row_end
	// segment items
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// seg_length[10:0], seg_midpoint[21:11], pattern_hit[22],
	// pattern_start[32:23], zero fill[39:33]
	output logic [prsp_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	output logic [prsp_pkg::TYPE_W-1:0]              m_axis_tuser,  // seg_type[1:0]
	output logic                                     m_axis_tlast   // last_of_row
);

	// run and row state
	logic [prsp_pkg::CFG_W-1:0] pattern_q;
	logic [prsp_pkg::PIX_W-1:0] run_val_q;
	logic                       run_open_q;
	logic [prsp_pkg::LEN_W-1:0] run_cnt_q;
	logic [prsp_pkg::LEN_W-1:0] run_first_q;
	logic [prsp_pkg::LEN_W-1:0] pos_q;
	prsp_pkg::row_t             row_q;

	// result queue
	prsp_pkg::res_t                 q_mem [prsp_pkg::QDEPTH];
	logic [prsp_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [prsp_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [prsp_pkg::QCNT_W-1:0]    q_cnt_q;

	logic                       in_acc;
	logic                       out_acc;
	logic [prsp_pkg::LEN_W-1:0] pos_n;
	logic [prsp_pkg::TYPE_W-1:0] cls;
	logic                       cont;
	logic                       close_a;
	logic                       open_new;
	logic                       run_open_n;
	logic [prsp_pkg::PIX_W-1:0] run_val_n;
	logic [prsp_pkg::LEN_W-1:0] run_cnt_n;
	logic [prsp_pkg::LEN_W-1:0] run_first_n;
	logic                       close_b;
	prsp_pkg::emit_t            em_a;
	prsp_pkg::emit_t            em_b;
	prsp_pkg::row_t             row_a;
	prsp_pkg::res_t             res0;
	prsp_pkg::res_t             res1;
	logic                       push0;
	logic                       push1;

	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = q_cnt_q <= prsp_pkg::QCNT_W'(prsp_pkg::QDEPTH - 2);

	// run tracking
	always_comb begin
		pos_n = (pos_q < prsp_pkg::LEN_W'(prsp_pkg::ROW_MAX)) ? pos_q + 1'b1 : pos_q;
		cls   = prsp_pkg::classify(s_axis_tdata);
		cont  = run_open_q && (cls != prsp_pkg::SEG_NONE) && (s_axis_tdata == run_val_q);
		close_a  = run_open_q && !cont;
		open_new = !cont && (cls != prsp_pkg::SEG_NONE);

		run_open_n  = cont || open_new;
		run_val_n   = open_new ? s_axis_tdata : run_val_q;
		run_first_n = open_new ? pos_n : run_first_q;
		if (open_new) begin
			run_cnt_n = prsp_pkg::LEN_W'(1);
		end else if (run_cnt_q < prsp_pkg::LEN_W'(prsp_pkg::ROW_MAX)) begin
			run_cnt_n = run_cnt_q + 1'b1;
		end else begin
			run_cnt_n = run_cnt_q;
		end
	end

	// segment closing and pattern compare, chained for two closes in one item
	always_comb begin
		em_a  = prsp_pkg::emit_seg(row_q, prsp_pkg::classify(run_val_q), run_cnt_q,
			run_first_q, pattern_q);
		row_a = close_a ? em_a.row : row_q;
		em_b  = prsp_pkg::emit_seg(row_a, prsp_pkg::classify(run_val_n), run_cnt_n,
			run_first_n, pattern_q);
		close_b = s_axis_tlast && run_open_n;
	end

	// pick result items and mark the last one of the row
	always_comb begin
		res0  = '0;
		res1  = em_b.res;
		push0 = 1'b0;
		push1 = 1'b0;
		if (close_a) begin
			res0  = em_a.res;
			push0 = 1'b1;
			push1 = close_b;
		end else if (close_b) begin
			res0  = em_b.res;
			push0 = 1'b1;
		end else if (s_axis_tlast) begin
			push0 = 1'b1;
		end
		if (s_axis_tlast) begin
			if (push1) res1.last_of_row = 1'b1;
			else res0.last_of_row = 1'b1;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= prsp_pkg::PATTERN_RESET;
			run_val_q   <= '0;
			run_open_q  <= 1'b0;
			run_cnt_q   <= '0;
			run_first_q <= '0;
			pos_q       <= '0;
			row_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) pattern_q <= cfg_data;
			if (in_acc) begin
				if (s_axis_tlast) begin
					run_val_q   <= '0;
					run_open_q  <= 1'b0;
					run_cnt_q   <= '0;
					run_first_q <= '0;
					pos_q       <= '0;
					row_q       <= '0;
				end else begin
					run_val_q   <= run_val_n;
					run_open_q  <= run_open_n;
					run_cnt_q   <= run_cnt_n;
					run_first_q <= run_first_n;
					pos_q       <= pos_n;
					row_q       <= row_a;
				end
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (in_acc && push0) q_mem[wr_ptr_q] <= res0;
		if (in_acc && push1) q_mem[wr_ptr_q + 1'b1] <= res1;
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (in_acc ? prsp_pkg::QPTR_W'({push1, push0 & ~push1}) : '0);
			rd_ptr_q <= rd_ptr_q + prsp_pkg::QPTR_W'(out_acc);
			q_cnt_q  <= q_cnt_q
				+ (in_acc ? prsp_pkg::QCNT_W'({push1, push0 & ~push1}) : '0)
				- prsp_pkg::QCNT_W'(out_acc);
		end
	end

	// output port
	assign m_axis_tvalid = q_cnt_q != '0;
	assign m_axis_tuser  = q_mem[rd_ptr_q].seg_type;
	assign m_axis_tlast  = q_mem[rd_ptr_q].last_of_row;
	assign m_axis_tdata  = {7'b0, q_mem[rd_ptr_q].pattern_start, q_mem[rd_ptr_q].pattern_hit,
		q_mem[rd_ptr_q].seg_midpoint, q_mem[rd_ptr_q].seg_length};

endmodule
`default_nettype wire

@@ dv/pixel_run_segmenter_pattern_detect_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_run_segmenter_pattern_detect_unit_tb
// Self-checking bench for the pixel run segmenter. Pixel rows go in through
// the slave stream. A predictor updated on each accepted pixel tracks runs,
// segment types and the pattern match, and checks every segment item field by
// field. The bench covers directed corner rows, random well-formed rows under
// several patterns, a saturating long row, random idling on both sides and
// one long output stall.
// ----------------------------------------------------------------------------
module pixel_run_segmenter_pattern_detect_unit_tb;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_AT       = 400;
	localparam int HOLD_CYCLES   = 120;
	localparam int ROW_PIXELS    = 50;

	// output tdata layout
	localparam int MID_LSB   = prsp_pkg::LEN_W;
	localparam int HIT_BIT   = 2 * prsp_pkg::LEN_W;
	localparam int START_LSB = 2 * prsp_pkg::LEN_W + 1;

	typedef struct packed {
		logic                       row_end;
		logic [prsp_pkg::PIX_W-1:0] pixel;
	} pixel_item_t;

	typedef struct packed {
		logic [prsp_pkg::TYPE_W-1:0] seg_type;
		logic [prsp_pkg::LEN_W-1:0]  length;
		logic [prsp_pkg::LEN_W-1:0]  midpoint;
		logic                        hit;
		logic [prsp_pkg::IDX_W-1:0]  first_idx;
		logic                        row_last;
	} segment_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [prsp_pkg::CFG_W-1:0]  cfg_data = '0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [prsp_pkg::PIX_W-1:0]  s_axis_tdata = '0;   // pixel[7:0]
	logic                        s_axis_tlast = 1'b0; // row_end
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	// seg_length[10:0], seg_midpoint[21:11], pattern_hit[22],
	// pattern_start[32:23], zero fill[39:33]
	logic [prsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [prsp_pkg::TYPE_W-1:0] m_axis_tuser;        // seg_type[1:0]
	logic                        m_axis_tlast;        // last_of_row

	pixel_item_t pending_pixels[$];
	segment_t    expected_segments[$];
	int          failures = 0;
	int          accepted_pixels = 0;
	int          cycle_count = 0;
	bit          pix_taken = 1'b0;
	bit          calm = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;
	int          pix_gap = 0;
	int          ready_gap = 0;

	// predictor state
	logic [prsp_pkg::CFG_W-1:0]  pattern_reg;
	logic [prsp_pkg::PIX_W-1:0]  run_pixel;
	bit                          run_active;
	int                          run_len;
	int                          run_start;
	int                          row_pos;
	logic [prsp_pkg::TYPE_W-1:0] type_hist[prsp_pkg::HIST_DEPTH];
	int                          seg_count;
	bit                          row_hit_seen;

	pixel_run_segmenter_pattern_detect_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// pixel classes
	function automatic logic [prsp_pkg::TYPE_W-1:0] type_of(logic [prsp_pkg::PIX_W-1:0] p);
		case (p)
			prsp_pkg::PIX_BLACK: return prsp_pkg::SEG_BLACK;
			prsp_pkg::PIX_GRAY:  return prsp_pkg::SEG_GRAY;
			prsp_pkg::PIX_WHITE: return prsp_pkg::SEG_WHITE;
			default:             return prsp_pkg::SEG_NONE;
		endcase
	endfunction

	function automatic logic [prsp_pkg::PIX_W-1:0] seg_pixel(logic [prsp_pkg::TYPE_W-1:0] t);
		case (t)
			prsp_pkg::SEG_BLACK: return prsp_pkg::PIX_BLACK;
			prsp_pkg::SEG_GRAY:  return prsp_pkg::PIX_GRAY;
			default:             return prsp_pkg::PIX_WHITE;
		endcase
	endfunction

	function automatic logic [prsp_pkg::PIX_W-1:0] noise_pixel();
		logic [prsp_pkg::PIX_W-1:0] p;
		do
			p = prsp_pkg::PIX_W'($urandom_range(0, 255));
		while (type_of(p) != prsp_pkg::SEG_NONE);
		return p;
	endfunction

	// pattern entry i, oldest segment first
	function automatic logic [prsp_pkg::TYPE_W-1:0] wanted_type(int i);
		return prsp_pkg::TYPE_W'(pattern_reg >> (prsp_pkg::TYPE_W * i));
	endfunction

	function automatic logic [prsp_pkg::CFG_W-1:0] rand_pattern();
		logic [prsp_pkg::CFG_W-1:0] p;
		p = '0;
		for (int i = 0; i < prsp_pkg::PATTERN_LEN; i++)
			p[prsp_pkg::TYPE_W*i +: prsp_pkg::TYPE_W] =
				prsp_pkg::TYPE_W'($urandom_range(1, 3));
		return p;
	endfunction

	task automatic clear_row();
		run_pixel    = '0;
		run_active   = 1'b0;
		run_len      = 0;
		run_start    = 0;
		row_pos      = 0;
		seg_count    = 0;
		row_hit_seen = 1'b0;
		for (int i = 0; i < prsp_pkg::HIST_DEPTH; i++)
			type_hist[i] = prsp_pkg::SEG_NONE;
	endtask

	// close the open run and run the pattern compare on it
	task automatic close_run(output segment_t seg);
		int                          mid;
		logic [prsp_pkg::TYPE_W-1:0] typ;
		logic                        match;
		typ = type_of(run_pixel);
		mid = run_start + run_len / 2;
		if (mid > prsp_pkg::ROW_MAX)
			mid = prsp_pkg::ROW_MAX;
		match = !row_hit_seen && seg_count >= prsp_pkg::PATTERN_LEN - 1
			&& typ == wanted_type(prsp_pkg::PATTERN_LEN - 1);
		for (int i = 0; i < prsp_pkg::HIST_DEPTH; i++)
			if (type_hist[i] != wanted_type(i))
				match = 1'b0;
		seg.seg_type  = typ;
		seg.length    = prsp_pkg::LEN_W'(run_len);
		seg.midpoint  = prsp_pkg::LEN_W'(mid);
		seg.hit       = match;
		seg.first_idx = match ?
			prsp_pkg::IDX_W'(seg_count - (prsp_pkg::PATTERN_LEN - 1)) : '0;
		seg.row_last  = 1'b0;
		if (match)
			row_hit_seen = 1'b1;
		for (int i = 0; i < prsp_pkg::HIST_DEPTH - 1; i++)
			type_hist[i] = type_hist[i+1];
		type_hist[prsp_pkg::HIST_DEPTH-1] = typ;
		if (seg_count < prsp_pkg::INDEX_MAX)
			seg_count++;
		run_active = 1'b0;
	endtask

	// one accepted pixel: update runs and queue the segments it closes
	task automatic predict_segments(pixel_item_t it);
		segment_t                    segs[2];
		int                          n;
		logic [prsp_pkg::TYPE_W-1:0] cls;
		bit                          continued;
		n = 0;
		continued = 1'b0;
		cls = type_of(it.pixel);
		if (row_pos < prsp_pkg::ROW_MAX)
			row_pos++;
		if (run_active) begin
			if (cls != prsp_pkg::SEG_NONE && it.pixel == run_pixel) begin
				if (run_len < prsp_pkg::ROW_MAX)
					run_len++;
				continued = 1'b1;
			end else begin
				close_run(segs[n]);
				n++;
			end
		end
		if (!continued && cls != prsp_pkg::SEG_NONE) begin
			run_active = 1'b1;
			run_pixel  = it.pixel;
			run_len    = 1;
			run_start  = row_pos;
		end
		if (it.row_end) begin
			if (run_active) begin
				close_run(segs[n]);
				n++;
			end
			// empty row end still yields one item
			if (n == 0) begin
				segs[0] = '0;
				n = 1;
			end
			segs[n-1].row_last = 1'b1;
			clear_row();
		end
		for (int i = 0; i < n; i++)
			expected_segments.push_back(segs[i]);
	endtask

	task automatic report_failure(string msg);
		$display("ERROR %0t: %s", $time, msg);
		failures++;
	endtask

	task automatic compare_field(string name, int got, int want);
		if (got != want)
			report_failure($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic check_segment();
		segment_t got;
		segment_t want;
		got.seg_type  = m_axis_tuser;
		got.length    = m_axis_tdata[prsp_pkg::LEN_W-1:0];
		got.midpoint  = m_axis_tdata[MID_LSB +: prsp_pkg::LEN_W];
		got.hit       = m_axis_tdata[HIT_BIT];
		got.first_idx = m_axis_tdata[START_LSB +: prsp_pkg::IDX_W];
		got.row_last  = m_axis_tlast;
		if (expected_segments.size() == 0) begin
			report_failure($sformatf("segment item with none expected, type %0d length %0d",
				got.seg_type, got.length));
		end else begin
			want = expected_segments.pop_front();
			compare_field("seg_type", got.seg_type, want.seg_type);
			compare_field("seg_length", got.length, want.length);
			compare_field("seg_midpoint", got.midpoint, want.midpoint);
			compare_field("pattern_hit", got.hit, want.hit);
			compare_field("pattern_start", got.first_idx, want.first_idx);
			compare_field("last_of_row", got.row_last, want.row_last);
		end
	endtask

	task automatic queue_pixel(logic [prsp_pkg::PIX_W-1:0] p, logic row_end);
		pixel_item_t it;
		it.pixel   = p;
		it.row_end = row_end;
		pending_pixels.push_back(it);
	endtask

	// random row, mostly following the current pattern so matches happen
	task automatic queue_row();
		int                          runs;
		int                          len;
		int                          offset;
		logic [prsp_pkg::TYPE_W-1:0] t;
		logic [prsp_pkg::TYPE_W-1:0] prev_t;
		if ($urandom_range(0, 19) == 0) begin
			queue_pixel(noise_pixel(), 1'b1);
			return;
		end
		runs = $urandom_range(1, 12);
		offset = $urandom_range(0, prsp_pkg::PATTERN_LEN - 1);
		prev_t = prsp_pkg::SEG_NONE;
		for (int k = 0; k < runs; k++) begin
			t = wanted_type((k + offset) % prsp_pkg::PATTERN_LEN);
			if (t == prsp_pkg::SEG_NONE || $urandom_range(0, 9) < 3)
				t = prsp_pkg::TYPE_W'($urandom_range(1, 3));
			// a skipped pixel keeps equal types apart
			if ((t == prev_t && $urandom_range(0, 9) < 6) || $urandom_range(0, 11) == 0)
				queue_pixel(noise_pixel(), 1'b0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 3);
			repeat (len) queue_pixel(seg_pixel(t), 1'b0);
			prev_t = t;
		end
		// row end on a skipped pixel, on a classified pixel, or on the last run
		case ($urandom_range(0, 3))
			0:       queue_pixel(noise_pixel(), 1'b1);
			1:       queue_pixel(seg_pixel(prsp_pkg::TYPE_W'($urandom_range(1, 3))), 1'b1);
			default: pending_pixels[pending_pixels.size()-1].row_end = 1'b1;
		endcase
	endtask

	task automatic queue_rows(int count);
		int start_size;
		start_size = pending_pixels.size();
		while (pending_pixels.size() - start_size < count)
			queue_row();
	endtask

	// wait until every pixel went in and every segment came out
	task automatic drain();
		while (pending_pixels.size() != 0 || expected_segments.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pattern(logic [prsp_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		pattern_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// pixel driver
	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && !pix_taken)) begin
			pix_taken = 1'b0;
			if (pix_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				pix_gap--;
			end else if (pending_pixels.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				s_axis_tvalid <= 1'b0;
				pix_gap = $urandom_range(0, 3);
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending_pixels[0].pixel;
				s_axis_tlast  <= pending_pixels[0].row_end;
			end
		end
	end

	// output ready: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (!hold_done && accepted_pixels >= HOLD_AT) begin
			m_axis_tready <= 1'b0;
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
		end else if (ready_gap > 0) begin
			m_axis_tready <= 1'b0;
			ready_gap--;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			ready_gap = $urandom_range(0, 3);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor: predict on accepted pixels, check accepted segments
	always @(posedge clk) begin : capture
		pixel_item_t it;
		if (s_axis_tvalid && s_axis_tready) begin
			it = pending_pixels.pop_front();
			pix_taken = 1'b1;
			accepted_pixels++;
			predict_segments(it);
		end
		if (m_axis_tvalid && m_axis_tready)
			check_segment();
	end

	// watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// stimulus phases
	initial begin : stimulus
		int k;
		clear_row();
		pattern_reg = prsp_pkg::PATTERN_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows under the reset pattern
		queue_pixel(8'd7, 1'b1);                            // empty row end
		queue_pixel(prsp_pkg::PIX_BLACK, 1'b0);             // match from index 0
		queue_pixel(prsp_pkg::PIX_BLACK, 1'b0);
		queue_pixel(prsp_pkg::PIX_WHITE, 1'b0);
		queue_pixel(prsp_pkg::PIX_GRAY, 1'b0);
		queue_pixel(prsp_pkg::PIX_GRAY, 1'b0);
		queue_pixel(prsp_pkg::PIX_WHITE, 1'b0);
		queue_pixel(prsp_pkg::PIX_BLACK, 1'b0);
		queue_pixel(prsp_pkg::PIX_BLACK, 1'b0);
		queue_pixel(prsp_pkg::PIX_WHITE, 1'b1);             // closes a run and a new one
		queue_pixel(prsp_pkg::PIX_WHITE, 1'b0);             // skipped pixel splits equal runs
		queue_pixel(8'd37, 1'b0);
		queue_pixel(prsp_pkg::PIX_WHITE, 1'b0);
		queue_pixel(prsp_pkg::PIX_GRAY, 1'b1);
		queue_pixel(8'd1, 1'b0);                            // values next to the classes
		queue_pixel(8'd254, 1'b0);
		queue_pixel(prsp_pkg::PIX_BLACK, 1'b0);
		queue_pixel(8'd127, 1'b0);
		queue_pixel(8'd129, 1'b0);
		queue_pixel(prsp_pkg::PIX_GRAY, 1'b1);
		queue_pixel(prsp_pkg::PIX_BLACK, 1'b0);             // row end on a skipped pixel
		queue_pixel(8'd99, 1'b1);
		drain();

		// no pattern can match
		write_pattern('0);
		queue_rows(ROW_PIXELS);
		drain();

		// all white pattern
		write_pattern('1);
		queue_rows(ROW_PIXELS);
		drain();

		// reset pattern again
		write_pattern(prsp_pkg::PATTERN_RESET);
		queue_rows(ROW_PIXELS);
		drain();

		// long row: position and segment index saturate, late match,
		// long output stall falls in here
		for (k = 0; k < prsp_pkg::ROW_MAX + 1; k++)
			queue_pixel((k % 2) ? prsp_pkg::PIX_WHITE : prsp_pkg::PIX_BLACK, 1'b0);
		queue_pixel(prsp_pkg::PIX_WHITE, 1'b0);
		queue_pixel(prsp_pkg::PIX_GRAY, 1'b0);
		queue_pixel(prsp_pkg::PIX_WHITE, 1'b0);
		queue_pixel(prsp_pkg::PIX_BLACK, 1'b0);
		queue_pixel(prsp_pkg::PIX_BLACK, 1'b0);
		queue_pixel(prsp_pkg::PIX_BLACK, 1'b1);
		drain();

		// random patterns
		for (k = 0; k < 4; k++) begin
			write_pattern((k == 0) ? prsp_pkg::CFG_W'($urandom_range(0, 1023))
				: rand_pattern());
			queue_rows(ROW_PIXELS);
			drain();
		end

		// last part without idling
		calm = 1'b1;
		write_pattern(rand_pattern());
		queue_rows(ROW_PIXELS);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		for (k = 0; k < 5000 && expected_segments.size() != 0; k++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_segments.size() != 0)
			report_failure($sformatf("%0d segment items never arrived",
				expected_segments.size()));

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
